@@ rtl/core/grc_pkg.sv @@
// Shared types and constants of the grid raycast column renderer.
package grc_pkg;

	localparam int unsigned POINT_CELL = 163840;
	localparam int unsigned FOV_UNITS = 8192;
	localparam int unsigned MAP_SIZE = 16;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEADING = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WALLS_0 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WALLS_1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WALLS_2 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WALLS_3 = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SIN,
		ST_COS,
		ST_MARCH,
		ST_CORNER,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic sin_go;
		logic cos_go;
		logic march_step;
		logic corner_step;
		logic div_step;
		logic emit_step;
	} cmd_t;

	typedef struct packed {
		logic trig_done;
		logic march_done;
		logic corner_done;
		logic div_done;
		logic emit_last;
	} status_t;

endpackage

@@ rtl/core/grc_ctrl.sv @@
// Sequencing state machine of the grid raycast column renderer.
module grc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  grc_pkg::status_t status,
	output grc_pkg::cmd_t    cmd
);

	grc_pkg::state_t state_q, state_d;
	logic            trig_phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grc_pkg::ST_IDLE;
			trig_phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == grc_pkg::ST_SIN || state_q == grc_pkg::ST_COS)
				trig_phase_q <= status.trig_done ? 1'b0 : 1'b1;
			else
				trig_phase_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			grc_pkg::ST_IDLE:   if (in_valid) state_d = grc_pkg::ST_SIN;
			grc_pkg::ST_SIN:    if (status.trig_done) state_d = grc_pkg::ST_COS;
			grc_pkg::ST_COS:    if (status.trig_done) state_d = grc_pkg::ST_MARCH;
			grc_pkg::ST_MARCH: begin
				if (status.march_done) state_d = grc_pkg::ST_CORNER;
			end
			grc_pkg::ST_CORNER: if (status.corner_done) state_d = grc_pkg::ST_DIV;
			grc_pkg::ST_DIV:    if (status.div_done) state_d = grc_pkg::ST_EMIT;
			grc_pkg::ST_EMIT: begin
				if (!out_stall && status.emit_last) state_d = grc_pkg::ST_IDLE;
			end
			default:            state_d = grc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			grc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.start = in_valid;
			end
			grc_pkg::ST_SIN:    cmd.sin_go = 1'b1;
			grc_pkg::ST_COS:    cmd.cos_go = 1'b1;
			grc_pkg::ST_MARCH:  cmd.march_step = 1'b1;
			grc_pkg::ST_CORNER: cmd.corner_step = 1'b1;
			grc_pkg::ST_DIV:    cmd.div_step = 1'b1;
			grc_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				cmd.emit_step = !out_stall;
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == grc_pkg::ST_EMIT))
		else $error("output valid outside emit");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != grc_pkg::ST_IDLE) |-> in_stall)
		else $error("input accepted while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && status.emit_last) |=> (state_q == grc_pkg::ST_IDLE))
		else $error("column did not finish");
	a_trig_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == grc_pkg::ST_IDLE) |=> !trig_phase_q)
		else $error("trig phase stuck");
`endif

endmodule

@@ rtl/core/grc_datapath.sv @@
// Datapath of the grid raycast column renderer: trig, march, corner test, rows.
module grc_datapath #(
	parameter int SCREEN_WIDTH = 120,
	parameter int SCREEN_HEIGHT = 40,
	parameter int MAX_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  grc_pkg::cmd_t      cmd,
	output grc_pkg::status_t   status,
	input  logic [6:0]         column,
	input  logic [15:0]        player_x,
	input  logic [15:0]        player_y,
	input  logic [15:0]        player_heading,
	input  logic [255:0]       walls,
	output logic [5:0]         row,
	output logic [3:0]         symbol,
	output logic               last_row
);

	localparam int KMAX = MAX_DEPTH * 10;
	localparam int KW = $clog2(KMAX + 1);
	localparam int RW = $clog2(SCREEN_HEIGHT);

	// Trig unit: four phases of polynomial, one multiply each.
	logic [15:0]        ang_q;
	logic [1:0]         tph_q;
	logic signed [31:0] tmp_q;
	logic signed [15:0] t_q, t2_q;
	logic signed [15:0] dx_q, dy_q;
	logic [1:0]         quad;
	logic [15:0]        trig_ang;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;
	logic [15:0]        off;
	logic [15:0]        off_tab [128];
	logic [13:0]        traw;
	logic signed [15:0] t_now;

	for (genvar g = 0; g < 128; g++) begin : g_off
		assign off_tab[g] = 16'((g * grc_pkg::FOV_UNITS) / SCREEN_WIDTH);
	end

	assign off = off_tab[column];
	assign trig_ang = cmd.cos_go ? ang_q + 16'h4000 : ang_q;
	assign quad = trig_ang[15:14];
	assign traw = trig_ang[13:0];
	assign t_now = quad[0] ? 16'sd16384 - 16'(traw) : 16'(traw);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (tph_q)
			2'd0: begin mul_a = 32'(t_now); mul_b = 32'(t_now); end
			2'd1: begin mul_a = 32'(t2_q); mul_b = 32'sd1160; end
			2'd2: begin mul_a = 32'(t2_q); mul_b = 32'sd10512 - tmp_q; end
			default: begin mul_a = 32'(t_q); mul_b = 32'sd25736 - tmp_q; end
		endcase
	end
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	logic trig_on;
	assign trig_on = cmd.sin_go || cmd.cos_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tph_q <= '0;
		else if (trig_on) tph_q <= tph_q + 2'd1;
		else tph_q <= '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.start)
			ang_q <= player_heading - 16'(grc_pkg::FOV_UNITS / 2) + off;
		if (trig_on && tph_q == 2'd0)
			t_q <= t_now;
		if (trig_on) begin
			unique case (tph_q)
				2'd0: t2_q <= 16'(mul_p >>> 14);
				2'd1, 2'd2: tmp_q <= 32'(mul_p >>> 14);
				default: begin
					if (cmd.sin_go) dx_q <= quad[1] ? -16'(mul_p >>> 14) : 16'(mul_p >>> 14);
					else dy_q <= quad[1] ? -16'(mul_p >>> 14) : 16'(mul_p >>> 14);
				end
			endcase
		end
	end
	// Phase 0 uses t from the angle directly.
	assign status.trig_done = trig_on && tph_q == 2'd3;

	// March: point accumulators in 1/163840 cell.
	logic signed [24:0] px_q, py_q;
	logic [KW-1:0]      k_q;
	logic               mdone_q, hit_q;
	logic [3:0]         hcx_q, hcy_q;
	logic signed [24:0] nx, ny;
	logic [4:0]         cx, cy;
	logic               outx, outy;

	assign nx = px_q + 25'(dx_q);
	assign ny = py_q + 25'(dy_q);

	function automatic logic [4:0] cell_f(input logic signed [24:0] p);
		logic [24:0] u;
		logic [4:0]  c;
		u = p;
		c = '0;
		for (int j = 1; j <= grc_pkg::MAP_SIZE; j++)
			if (u >= 25'(j * grc_pkg::POINT_CELL)) c = 5'(j);
		if (p <= -25'sd163840) cell_f = 5'h10;
		else if (p < 0) cell_f = 5'd0;
		else cell_f = c;
	endfunction

	assign cx = cell_f(nx);
	assign cy = cell_f(ny);
	assign outx = cx[4];
	assign outy = cy[4];

	logic wall_bit;
	assign wall_bit = walls[{cy[3:0], cx[3:0]}];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mdone_q <= 1'b0;
			hit_q <= 1'b0;
		end else if (cmd.start) begin
			mdone_q <= 1'b0;
			hit_q <= 1'b0;
		end else if (cmd.march_step && !mdone_q) begin
			if (outx || outy) begin
				mdone_q <= 1'b1;
			end else if (wall_bit) begin
				mdone_q <= 1'b1;
				hit_q <= 1'b1;
			end else if (k_q == KW'(KMAX)) begin
				mdone_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q <= 25'(32'(player_x) * 40);
			py_q <= 25'(32'(player_y) * 40);
			k_q <= KW'(1);
		end else if (cmd.march_step && !mdone_q) begin
			hcx_q <= cx[3:0];
			hcy_q <= cy[3:0];
			if (outx || outy) begin
				k_q <= KW'(KMAX);
			end else if (!wall_bit && k_q != KW'(KMAX)) begin
				k_q <= k_q + KW'(1);
				px_q <= nx;
				py_q <= ny;
			end
		end
	end
	assign status.march_done = cmd.march_step && mdone_q;

	// Corner test, one corner per cycle, then rank.
	logic [2:0]         ci_q;
	logic [33:0]        len_q [4];
	logic [3:0]         onr_q;
	logic signed [17:0] vx, vy;
	logic signed [35:0] dot_c, cr_c, cra;
	logic [33:0]        lc;

	assign vx = 18'(({1'b0, hcx_q} + 5'(ci_q[1])) * 18'd4096) - 18'(player_x);
	assign vy = 18'(({1'b0, hcy_q} + 5'(ci_q[0])) * 18'd4096) - 18'(player_y);
	assign dot_c = 36'(dx_q) * 36'(vx) + 36'(dy_q) * 36'(vy);
	assign cr_c = 36'(dx_q) * 36'(vy) - 36'(dy_q) * 36'(vx);
	assign cra = cr_c < 0 ? -cr_c : cr_c;
	assign lc = 34'(vx * vx) + 34'(vy * vy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ci_q <= '0;
		else if (cmd.start) ci_q <= '0;
		else if (cmd.corner_step && !ci_q[2]) ci_q <= ci_q + 3'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.corner_step && !ci_q[2]) begin
			len_q[ci_q[1:0]] <= lc;
			onr_q[ci_q[1:0]] <= dot_c > 0 && 43'(cra) * 43'sd100 < 43'(dot_c);
		end
	end
	assign status.corner_done = cmd.corner_step && ci_q[2];

	logic boundary;
	always_comb begin
		logic [2:0] rk;
		boundary = 1'b0;
		for (int i = 0; i < 4; i++) begin
			rk = '0;
			for (int j = 0; j < 4; j++)
				if (len_q[j] < len_q[i] || (len_q[j] == len_q[i] && j < i)) rk = rk + 3'd1;
			if (rk < 3'd2 && onr_q[i]) boundary = 1'b1;
		end
		boundary = boundary && hit_q;
	end

	// Ceiling = H*(k-20)/(2k): restoring division, one bit a cycle.
	localparam int NW = $clog2(SCREEN_HEIGHT * KMAX + 1);
	logic [NW-1:0]  rem_q, quo_q;
	logic [$clog2(NW+1)-1:0] dc_q;
	logic           neg_q;
	logic [NW:0]    trial;
	logic signed [NW:0] ceil_q;
	logic [3:0]     shade_q;
	logic [NW-1:0]  den;

	assign den = NW'({k_q, 1'b0});
	assign trial = {rem_q, quo_q[NW-1]} - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dc_q <= '0;
		else if (cmd.start) dc_q <= '0;
		else if (cmd.div_step && dc_q <= NW) dc_q <= dc_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_step) begin
			if (dc_q == 0) begin
				neg_q <= k_q < KW'(20);
				quo_q <= k_q < KW'(20) ? NW'(SCREEN_HEIGHT * (20 - k_q))
				                       : NW'(SCREEN_HEIGHT * (k_q - 20));
				rem_q <= '0;
				if (4 * k_q <= 10 * MAX_DEPTH) shade_q <= 4'd1;
				else if (3 * k_q < 10 * MAX_DEPTH) shade_q <= 4'd2;
				else if (2 * k_q < 10 * MAX_DEPTH) shade_q <= 4'd3;
				else if (k_q < KW'(KMAX)) shade_q <= 4'd4;
				else shade_q <= 4'd0;
			end else if (dc_q <= NW) begin
				if (!trial[NW]) begin
					rem_q <= trial[NW-1:0];
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[NW-2:0], quo_q[NW-1]};
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
			end else begin
				ceil_q <= neg_q ? -(NW+1)'(quo_q) : (NW+1)'(quo_q);
				if (boundary) shade_q <= 4'd0;
			end
		end
	end
	assign status.div_done = cmd.div_step && dc_q == NW + 1;

	// Row emitter.
	logic [RW-1:0] y_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) y_q <= '0;
		else if (cmd.start) y_q <= '0;
		else if (cmd.emit_step) y_q <= y_q + 1'b1;
	end

	logic signed [NW:0] ys, fl;
	logic [RW+4:0]      m;
	assign ys = (NW+1)'(y_q);
	assign fl = (NW+1)'(SCREEN_HEIGHT) - ceil_q;
	assign m = (RW+5)'(SCREEN_HEIGHT) - (RW+5)'(y_q);

	always_comb begin
		if (ys < ceil_q) symbol = 4'd0;
		else if (ys > ceil_q && ys <= fl) symbol = shade_q;
		else if (8 * m < SCREEN_HEIGHT) symbol = 4'd5;
		else if (4 * m < SCREEN_HEIGHT) symbol = 4'd6;
		else if (8 * m < 3 * SCREEN_HEIGHT) symbol = 4'd7;
		else if (20 * m < 9 * SCREEN_HEIGHT) symbol = 4'd8;
		else symbol = 4'd0;
	end
	assign row = 6'(y_q);
	assign last_row = y_q == RW'(SCREEN_HEIGHT - 1);
	assign status.emit_last = last_row;

`ifndef NO_ASSERTIONS
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (k_q >= KW'(1) && k_q <= KW'(KMAX)))
		else $error("distance out of range");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_step |-> (int'(y_q) < SCREEN_HEIGHT))
		else $error("row out of range");
	a_corner_count: assert property (@(posedge clk) disable iff (!arst_n)
		status.corner_done |-> ci_q == 3'd4)
		else $error("corner count wrong");
`endif

endmodule

@@ rtl/core/grid_raycast_column_renderer_unit.sv @@
// Top level of the grid raycast column renderer.
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | column
// out     | output    | out_valid / out_stall| row, symbol, last_row
// cfg     | input     | cfg_we               | cfg_index, cfg_data
// A column passes through the accept, sine, cosine, march, corner, divider and emit states,
// one row per transaction in emit.
// Reset loads the player at the map center facing heading zero, no walls.
// Output stall freezes the row counter; input is stalled until the column ends.
module grid_raycast_column_renderer_unit #(
	parameter int SCREEN_WIDTH = 120,
	parameter int SCREEN_HEIGHT = 40,
	parameter int MAX_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [6:0]  column,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  row,
	output logic [3:0]  symbol,
	output logic        last_row,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [15:0]  player_x_q, player_y_q, heading_q;
	logic [255:0] walls_q;
	grc_pkg::cmd_t    cmd;
	grc_pkg::status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_x_q <= 16'h8000;
			player_y_q <= 16'h8000;
			heading_q <= '0;
			walls_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				grc_pkg::REG_PLAYER_X: player_x_q <= cfg_data[15:0];
				grc_pkg::REG_PLAYER_Y: player_y_q <= cfg_data[15:0];
				grc_pkg::REG_HEADING:  heading_q <= cfg_data[15:0];
				grc_pkg::REG_WALLS_0:  walls_q[63:0] <= cfg_data;
				grc_pkg::REG_WALLS_1:  walls_q[127:64] <= cfg_data;
				grc_pkg::REG_WALLS_2:  walls_q[191:128] <= cfg_data;
				grc_pkg::REG_WALLS_3:  walls_q[255:192] <= cfg_data;
				default: ;
			endcase
		end
	end

	grc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
	);

	grc_datapath #(
		.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT),
		.MAX_DEPTH(MAX_DEPTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status), .column(column),
		.player_x(player_x_q), .player_y(player_y_q), .player_heading(heading_q),
		.walls(walls_q), .row(row), .symbol(symbol), .last_row(last_row)
	);

endmodule

@@ dv/grid_raycast_column_renderer_unit_tb.sv @@
// Self-checking testbench of the grid raycast column renderer with random handshake idling.
module grid_raycast_column_renderer_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIDTH = 120;
	localparam int HEIGHT = 40;
	localparam int DEPTH = 16;
	localparam int IDLE_LIMIT = 20000;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic [5:0] row;
		logic [3:0] symbol;
		logic       last_row;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [6:0]  column = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [5:0]  row;
	logic [3:0]  symbol;
	logic        last_row;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	logic [15:0] pos_x, pos_y, heading;
	logic [63:0] wall_bits [4];

	logic [6:0] column_queue [$];
	pixel_t     pixel_queue [$];
	int         fail_count = 0;
	int         idle_cycles = 0;
	int         burst_left = 0;
	int         gap_left = 0;
	int         stall_mode = 0;
	bit         hold_sender = 1'b0;

	grid_raycast_column_renderer_unit i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint quarter_wave(longint t);
		longint t2, inner, mid;
		t2 = (t * t) >>> 14;
		inner = 10512 - ((t2 * 1160) >>> 14);
		mid = 25736 - ((t2 * inner) >>> 14);
		return (t * mid) >>> 14;
	endfunction

	function automatic longint sine_of(logic [15:0] a);
		longint t, s;
		t = a[13:0];
		if (a[14])
			t = 16384 - t;
		s = quarter_wave(t);
		return a[15] ? -s : s;
	endfunction

	function automatic int map_cell(longint p);
		if (p <= -longint'(grc_pkg::POINT_CELL))
			return -1;
		if (p < 0)
			return 0;
		if (p / grc_pkg::POINT_CELL >= 16)
			return -1;
		return int'(p / grc_pkg::POINT_CELL);
	endfunction

	function automatic bit wall_at(int cx, int cy);
		return wall_bits[(cy >> 2) & 3][(cy & 3) * 16 + (cx & 15)];
	endfunction

	function automatic bit hits_corner(int cx, int cy, longint dx, longint dy);
		longint len [4];
		bit     on_ray [4];
		longint vx, vy, dot, cr;
		int     rank;
		bit     found;
		found = 1'b0;
		for (int i = 0; i < 4; i++) begin
			vx = longint'(cx + (i >> 1)) * 4096 - longint'(pos_x);
			vy = longint'(cy + (i & 1)) * 4096 - longint'(pos_y);
			dot = dx * vx + dy * vy;
			cr = dx * vy - dy * vx;
			if (cr < 0)
				cr = -cr;
			len[i] = vx * vx + vy * vy;
			on_ray[i] = dot > 0 && 100 * cr < dot;
		end
		for (int i = 0; i < 4; i++) begin
			rank = 0;
			for (int j = 0; j < 4; j++)
				if (len[j] < len[i] || (len[j] == len[i] && j < i))
					rank++;
			if (rank < 2 && on_ray[i])
				found = 1'b1;
		end
		return found;
	endfunction

	task automatic enqueue_column(logic [6:0] col);
		column_queue.insert(column_queue.size(), col);
	endtask

	task automatic render_column(logic [6:0] col);
		logic [15:0] ang;
		longint dx, dy, k, kmax, num, ceil_row, floor_row, m;
		int cx, cy;
		bit corner;
		logic [3:0] shade, sym;
		pixel_t px;
		ang = heading + 16'(65536 - grc_pkg::FOV_UNITS / 2)
			+ 16'((int'(col) * grc_pkg::FOV_UNITS) / WIDTH);
		dx = sine_of(ang);
		dy = sine_of(ang + 16'd16384);
		kmax = DEPTH * 10;
		corner = 1'b0;
		for (k = 1; k <= kmax; k++) begin
			cx = map_cell(longint'(pos_x) * 40 + dx * k);
			cy = map_cell(longint'(pos_y) * 40 + dy * k);
			if (cx < 0 || cy < 0) begin
				k = kmax;
				break;
			end
			if (wall_at(cx, cy)) begin
				corner = hits_corner(cx, cy, dx, dy);
				break;
			end
		end
		if (k > kmax)
			k = kmax;
		num = HEIGHT * (k - 20);
		ceil_row = num >= 0 ? num / (2 * k) : -((-num) / (2 * k));
		floor_row = HEIGHT - ceil_row;
		if (4 * k <= 10 * DEPTH)
			shade = 1;
		else if (3 * k < 10 * DEPTH)
			shade = 2;
		else if (2 * k < 10 * DEPTH)
			shade = 3;
		else if (k < 10 * DEPTH)
			shade = 4;
		else
			shade = 0;
		if (corner)
			shade = 0;
		for (int y = 0; y < HEIGHT; y++) begin
			if (y < ceil_row) begin
				sym = 0;
			end else if (y > ceil_row && y <= floor_row) begin
				sym = shade;
			end else begin
				m = HEIGHT - y;
				if (8 * m < HEIGHT)
					sym = 5;
				else if (4 * m < HEIGHT)
					sym = 6;
				else if (8 * m < 3 * HEIGHT)
					sym = 7;
				else if (20 * m < 9 * HEIGHT)
					sym = 8;
				else
					sym = 0;
			end
			px.row = 6'(y);
			px.symbol = sym;
			px.last_row = (y == HEIGHT - 1);
			pixel_queue.insert(pixel_queue.size(), px);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			render_column(column);
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_queue.size() == 0) begin
				$error("row transaction with nothing expected: row %0d", row);
				fail_count++;
			end else begin
				if (row !== pixel_queue[0].row) begin
					$error("row: expected %0d, actual %0d", pixel_queue[0].row, row);
					fail_count++;
				end
				if (symbol !== pixel_queue[0].symbol) begin
					$error("symbol: expected %0d, actual %0d", pixel_queue[0].symbol, symbol);
					fail_count++;
				end
				if (last_row !== pixel_queue[0].last_row) begin
					$error("last_row: expected %0d, actual %0d",
						pixel_queue[0].last_row, last_row);
					fail_count++;
				end
				void'(pixel_queue.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				void'(column_queue.pop_front());
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (!hold_sender && column_queue.size() > 0) begin
					in_valid <= 1'b1;
					column <= column_queue[0];
					if (burst_left > 0) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(0, 6);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 199) == 0)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 1) == 0);
				default: out_stall <= ($urandom_range(0, 15) < 13);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			grc_pkg::REG_PLAYER_X: pos_x = value[15:0];
			grc_pkg::REG_PLAYER_Y: pos_y = value[15:0];
			grc_pkg::REG_HEADING: heading = value[15:0];
			grc_pkg::REG_WALLS_0, grc_pkg::REG_WALLS_1, grc_pkg::REG_WALLS_2,
			grc_pkg::REG_WALLS_3:
				wall_bits[idx - grc_pkg::REG_WALLS_0] = value;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (column_queue.size() > 0 || in_valid || pixel_queue.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [63:0] random_walls(int density);
		logic [63:0] w;
		for (int b = 0; b < 64; b++)
			w[b] = ($urandom_range(0, 99) < density);
		return w;
	endfunction

	task automatic random_scene(int density);
		write_reg(grc_pkg::REG_PLAYER_X, {$urandom, $urandom});
		write_reg(grc_pkg::REG_PLAYER_Y, {$urandom, $urandom});
		write_reg(grc_pkg::REG_HEADING, {$urandom, $urandom});
		for (int r = 0; r < 4; r++)
			write_reg(grc_pkg::REG_WALLS_0 + 3'(r), random_walls(density));
	endtask

	initial begin
		pos_x = 16'd32768;
		pos_y = 16'd32768;
		heading = 16'd0;
		for (int r = 0; r < 4; r++)
			wall_bits[r] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Empty map: the ray leaves the map, with columns at the extremes.
		enqueue_column(7'd0);
		enqueue_column(7'd127);
		enqueue_column(7'd119);
		enqueue_column(7'd60);
		drain();
		write_reg(REG_UNUSED, '1);
		write_reg(grc_pkg::REG_WALLS_0, 64'hFFFF_8001_8001_8001);
		write_reg(grc_pkg::REG_WALLS_1, 64'h8001_8001_8001_8001);
		write_reg(grc_pkg::REG_WALLS_2, 64'h8001_8001_8001_8001);
		write_reg(grc_pkg::REG_WALLS_3, 64'hFFFF_8001_8001_8001);
		write_reg(grc_pkg::REG_HEADING, 64'hFFFF_FFFF_FFFF_FFFF);
		for (int c = 0; c < 8; c++)
			enqueue_column(7'(c * 17));
		drain();
		// Player on a cell corner next to a wall block, corner rays included.
		write_reg(grc_pkg::REG_PLAYER_X, 64'h0000_4000);
		write_reg(grc_pkg::REG_PLAYER_Y, 64'h0000_4000);
		write_reg(grc_pkg::REG_HEADING, 64'h0000_2000);
		write_reg(grc_pkg::REG_WALLS_1, 64'h0000_0000_0000_00F0);
		for (int c = 0; c < 6; c++)
			enqueue_column(7'($urandom_range(50, 70)));
		drain();
		// Map edges: player at the extremes of the position range.
		write_reg(grc_pkg::REG_PLAYER_X, 64'h0);
		write_reg(grc_pkg::REG_PLAYER_Y, 64'hFFFF);
		write_reg(grc_pkg::REG_HEADING, 64'h8000);
		for (int c = 0; c < 4; c++)
			enqueue_column(7'($urandom_range(0, 127)));
		drain();

		for (int phase = 0; phase < 12; phase++) begin
			random_scene(phase % 3 == 0 ? 0 : (phase % 3 == 1 ? 15 : 60));
			for (int c = 0; c < 20; c++)
				enqueue_column(7'($urandom_range(0, 127)));
			if (phase == 5) begin
				while (column_queue.size() > 10)
					@(posedge clk);
				hold_sender = 1'b1;
				@(posedge clk);
				while (pixel_queue.size() > 0 || in_valid)
					@(posedge clk);
				hold_sender = 1'b0;
			end
			drain();
		end

		if (fail_count == 0 && pixel_queue.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
